### src/rfg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfg_pkg: shared definitions for the rotated font glyph renderer
// Font table, glyph lookup, coordinate saturation, codes and shared types.
// ----------------------------------------------------------------------------
package rfg_pkg;

	localparam int COORD_W      = 16;
	localparam int SAT_W        = COORD_W + 2;
	localparam int SCALE_W      = 5;
	localparam int SCALE_MAX    = 16;
	localparam int DOT_COLS     = 5;
	localparam int DOT_ROWS     = 7;
	localparam int GLYPH_BITS   = DOT_COLS * DOT_ROWS;
	localparam int FONT_ENTRIES = 37;
	localparam int POS_W        = 3;
	localparam int PROD_W       = POS_W + SCALE_W;
	localparam int CHAR_GAP_DEF = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int MODE_W       = 3;

	localparam logic [7:0] ASCII_LC_A  = 8'h61;
	localparam logic [7:0] ASCII_LC_Z  = 8'h7A;
	localparam logic [7:0] ASCII_UC_A  = 8'h41;
	localparam logic [7:0] ASCII_UC_Z  = 8'h5A;
	localparam logic [7:0] ASCII_0     = 8'h30;
	localparam logic [7:0] ASCII_9     = 8'h39;
	localparam logic [7:0] ASCII_DASH  = 8'h2D;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [5:0] DIGIT_BASE  = 6'd26;
	localparam logic [5:0] DASH_INDEX  = 6'd36;

	typedef logic [GLYPH_BITS-1:0] glyph_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADVANCE
	} state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_GLYPH_SCALE,
		REG_TRANSFORM_MODE
	} reg_index_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_NORMAL,
		MODE_ROT_LEFT,
		MODE_ROT_RIGHT,
		MODE_VFLIP,
		MODE_ROT_180
	} mode_t;

	typedef struct packed {
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
	} dot_pos_t;

	// Row 0 sits in the top bits; within a row the leftmost column is the top bit.
	localparam glyph_t FONT [FONT_ENTRIES] = '{
		{5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
		{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
		{5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
		{5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
		{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
		{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
		{5'h0E,5'h11,5'h10,5'h10,5'h13,5'h11,5'h0E},
		{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
		{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F},
		{5'h01,5'h01,5'h01,5'h01,5'h11,5'h11,5'h0E},
		{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
		{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
		{5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
		{5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11},
		{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
		{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
		{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
		{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
		{5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
		{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
		{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
		{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
		{5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A},
		{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
		{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04},
		{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
		{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E},
		{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
		{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F},
		{5'h1E,5'h01,5'h01,5'h06,5'h01,5'h01,5'h1E},
		{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02},
		{5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E},
		{5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E},
		{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
		{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
		{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E},
		{5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00}
	};

	function automatic glyph_t glyph_lookup(input logic [7:0] code);
		logic [7:0] c;
		glyph_t     g;
		c = code;
		g = '0;
		if (c >= ASCII_LC_A && c <= ASCII_LC_Z) begin
			c = c - CASE_OFFSET;
		end
		if (c >= ASCII_UC_A && c <= ASCII_UC_Z) begin
			g = FONT[6'(c - ASCII_UC_A)];
		end else if (c >= ASCII_0 && c <= ASCII_9) begin
			g = FONT[DIGIT_BASE + 6'(c - ASCII_0)];
		end else if (c == ASCII_DASH) begin
			g = FONT[DASH_INDEX];
		end
		return g;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if ((&v[SAT_W-1:COORD_W-1]) || !(|v[SAT_W-1:COORD_W-1])) begin
			r = v[COORD_W-1:0];
		end else if (v[SAT_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### src/rfg_coord_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfg_coord_unit: dot placement
// Maps a font dot position through the selected transform, scales it and
// adds it to the text cursor with saturation.
// ----------------------------------------------------------------------------
module rfg_coord_unit import rfg_pkg::*; (
	input  wire logic [MODE_W-1:0]         mode,
	input  wire dot_pos_t                  pos,
	input  wire logic [SCALE_W-1:0]        scale,
	input  wire logic signed [COORD_W-1:0] cursor_x,
	input  wire logic signed [COORD_W-1:0] cursor_y,
	output logic signed [COORD_W-1:0]      dot_x,
	output logic signed [COORD_W-1:0]      dot_y
);

	localparam logic [POS_W-1:0] COL_LAST = POS_W'(DOT_COLS - 1);
	localparam logic [POS_W-1:0] ROW_LAST = POS_W'(DOT_ROWS - 1);

	logic [POS_W-1:0]        ox;
	logic [POS_W-1:0]        oy;
	logic [PROD_W-1:0]       prod_x;
	logic [PROD_W-1:0]       prod_y;
	logic signed [SAT_W-1:0] sum_x;
	logic signed [SAT_W-1:0] sum_y;

	always_comb begin
		case (mode)
			MODE_ROT_LEFT: begin
				ox = pos.row;
				oy = COL_LAST - pos.col;
			end
			MODE_ROT_RIGHT: begin
				ox = ROW_LAST - pos.row;
				oy = pos.col;
			end
			MODE_VFLIP: begin
				ox = pos.col;
				oy = ROW_LAST - pos.row;
			end
			MODE_ROT_180: begin
				ox = COL_LAST - pos.col;
				oy = ROW_LAST - pos.row;
			end
			default: begin
				ox = pos.col;
				oy = pos.row;
			end
		endcase
	end

	assign prod_x = {{SCALE_W{1'b0}}, ox} * {{POS_W{1'b0}}, scale};
	assign prod_y = {{SCALE_W{1'b0}}, oy} * {{POS_W{1'b0}}, scale};

	assign sum_x = {{(SAT_W-COORD_W){cursor_x[COORD_W-1]}}, cursor_x}
		+ {{(SAT_W-PROD_W){1'b0}}, prod_x};
	assign sum_y = {{(SAT_W-COORD_W){cursor_y[COORD_W-1]}}, cursor_y}
		+ {{(SAT_W-PROD_W){1'b0}}, prod_y};

	assign dot_x = sat_coord(sum_x);
	assign dot_y = sat_coord(sum_y);

endmodule
`default_nettype wire

### src/rotated_font_glyph_renderer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_font_glyph_renderer_top: 5x7 character generator with rotation
// Turns a stream of characters into the corners of scaled squares, one per
// set font dot, and keeps the text cursor.
// ----------------------------------------------------------------------------
// One character item is taken while the block is idle; the sequencer then
// walks the glyph one font dot per cycle through a single placement unit,
// pausing while the output register is held by out_ready low, stops after
// the last set dot and then moves the cursor in the advance state. Squares
// come out in row-major order of the font dots, and the final square of a
// character carries last_of_char.
module rotated_font_glyph_renderer_top import rfg_pkg::*; #(
	parameter int CHAR_GAP = CHAR_GAP_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [COORD_W-1:0]      cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [7:0]              char_code,
	input  wire logic                    end_of_text,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [COORD_W-1:0]    block_x,
	output logic signed [COORD_W-1:0]    block_y,
	output logic                         last_of_char
);

	localparam int STEP_MULT = DOT_COLS + CHAR_GAP;
	localparam int STEP_W    = $clog2(STEP_MULT * SCALE_MAX + 1);
	localparam logic [POS_W-1:0] COL_LAST = POS_W'(DOT_COLS - 1);

	state_t                    state_q;
	state_t                    state_d;
	logic signed [COORD_W-1:0] origin_x_q;
	logic signed [COORD_W-1:0] origin_y_q;
	logic [SCALE_W-1:0]        scale_q;
	logic [MODE_W-1:0]         mode_q;
	logic signed [COORD_W-1:0] cursor_x_q;
	logic signed [COORD_W-1:0] cursor_y_q;
	logic                      at_start_q;
	logic                      eot_q;
	glyph_t                    bits_q;
	dot_pos_t                  pos_q;
	logic                      out_valid_q;
	logic signed [COORD_W-1:0] block_x_q;
	logic signed [COORD_W-1:0] block_y_q;
	logic                      last_q;

	logic [SCALE_W-1:0]        scale_c;
	logic [STEP_W-1:0]         step;
	logic signed [SAT_W-1:0]   adv_sum;
	logic signed [SAT_W-1:0]   adv_base;
	logic signed [COORD_W-1:0] dot_x;
	logic signed [COORD_W-1:0] dot_y;
	logic                      accept;
	logic                      scan_go;
	logic                      rest_empty;

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign block_x      = block_x_q;
	assign block_y      = block_y_q;
	assign last_of_char = last_q;

	always_comb begin
		if (scale_q == '0) begin
			scale_c = SCALE_W'(1);
		end else if (scale_q > SCALE_W'(SCALE_MAX)) begin
			scale_c = SCALE_W'(SCALE_MAX);
		end else begin
			scale_c = scale_q;
		end
	end

	assign accept     = in_valid && in_ready;
	assign scan_go    = (state_q == ST_SCAN) && (!out_valid_q || out_ready);
	assign rest_empty = ~|bits_q[GLYPH_BITS-2:0];

	rfg_coord_unit u_coord (
		.mode     (mode_q),
		.pos      (pos_q),
		.scale    (scale_c),
		.cursor_x (cursor_x_q),
		.cursor_y (cursor_y_q),
		.dot_x    (dot_x),
		.dot_y    (dot_y)
	);

	assign step     = STEP_W'(STEP_MULT * scale_c);
	assign adv_base = (mode_q == MODE_ROT_LEFT || mode_q == MODE_ROT_RIGHT)
		? {{(SAT_W-COORD_W){cursor_y_q[COORD_W-1]}}, cursor_y_q}
		: {{(SAT_W-COORD_W){cursor_x_q[COORD_W-1]}}, cursor_x_q};
	assign adv_sum  = (mode_q == MODE_ROT_LEFT)
		? adv_base - {{(SAT_W-STEP_W){1'b0}}, step}
		: adv_base + {{(SAT_W-STEP_W){1'b0}}, step};

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_go && rest_empty) begin
					state_d = ST_ADVANCE;
				end
			end
			ST_ADVANCE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			scale_q    <= SCALE_W'(1);
			mode_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X:       origin_x_q <= cfg_data;
				REG_ORIGIN_Y:       origin_y_q <= cfg_data;
				REG_GLYPH_SCALE:    scale_q    <= cfg_data[SCALE_W-1:0];
				REG_TRANSFORM_MODE: mode_q     <= cfg_data[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			at_start_q <= 1'b1;
		end else if (accept && at_start_q) begin
			cursor_x_q <= origin_x_q;
			cursor_y_q <= origin_y_q;
			at_start_q <= 1'b0;
		end else if (state_q == ST_ADVANCE) begin
			if (mode_q == MODE_ROT_LEFT || mode_q == MODE_ROT_RIGHT) begin
				cursor_y_q <= sat_coord(adv_sum);
			end else begin
				cursor_x_q <= sat_coord(adv_sum);
			end
			at_start_q <= eot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bits_q <= glyph_lookup(char_code);
			eot_q  <= end_of_text;
			pos_q  <= '0;
		end else if (scan_go) begin
			bits_q <= {bits_q[GLYPH_BITS-2:0], 1'b0};
			if (pos_q.col == COL_LAST) begin
				pos_q.col <= '0;
				pos_q.row <= pos_q.row + POS_W'(1);
			end else begin
				pos_q.col <= pos_q.col + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (scan_go && bits_q[GLYPH_BITS-1]) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_go && bits_q[GLYPH_BITS-1]) begin
			block_x_q <= dot_x;
			block_y_q <= dot_y;
			last_q    <= rest_empty;
		end
	end

endmodule
`default_nettype wire

### src/rfg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfg_checker: port-level checks for the glyph renderer
// Watches the handshakes of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module rfg_checker import rfg_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [COORD_W-1:0]   block_x,
	input wire logic [COORD_W-1:0]   block_y,
	input wire logic                 last_of_char
);

	// A held result keeps its value until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(block_x) && $stable(block_y)
			&& $stable(last_of_char))
	else $error("held output item changed");

	// The block is busy right after it takes a character.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input taken while busy");

	// A square that is not the last of its character holds the input off.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_char |-> !in_ready)
	else $error("character taken while another is still being drawn");

	// Every character passes through the scan and then the advance state before the block is idle again.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 !in_ready)
	else $error("character finished too early");

endmodule

bind rotated_font_glyph_renderer_top rfg_checker u_rfg_checker (.*);
`default_nettype wire
